// ===== src/vtrs_pkg.sv =====
// Shared constants and control types for the virtual-time rate shaper.
`default_nettype none

package vtrs_pkg;

	localparam int TIME_W  = 48;
	localparam int COUNT_W = 32;
	localparam int RATE_W  = 40;

	localparam int TICKS_PER_SECOND_DEF = 1000000000;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_ADD
	} vtrs_state_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;    // capture request, load result registers
		logic mul;       // form bytes * ticks-per-second
		logic div_step;  // one restoring division step
		logic commit;    // saturating update of next release time
	} vtrs_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic limit_on;  // rate and byte count both nonzero on the input
	} vtrs_sts_t;

endpackage

`default_nettype wire

// ===== src/vtrs_ctrl.sv =====
// Sequencer for the shaper: handshakes, multiply / divide / commit steps.
`default_nettype none

module vtrs_ctrl #(
	parameter int DIV_STEPS = 62
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  wire               out_stall,
	input  vtrs_pkg::vtrs_sts_t sts,
	output vtrs_pkg::vtrs_cmd_t cmd
);
	import vtrs_pkg::*;

	localparam int CNT_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

	vtrs_state_t      state_q;
	vtrs_state_t      state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             accept;

	assign out_valid = out_valid_q;
	// result register is free once it is empty or being taken this cycle
	assign in_stall  = (state_q != ST_IDLE) || (out_valid_q && out_stall);
	assign accept    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_MUL) begin
				cnt_q <= '0;
			end else if (state_q == ST_DIV) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd.accept   = 1'b0;
		cmd.mul      = 1'b0;
		cmd.div_step = 1'b0;
		cmd.commit   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.accept = accept;
				if (accept && sts.limit_on) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					state_d = ST_ADD;
				end
			end
			ST_ADD: begin
				cmd.commit = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== src/vtrs_dp.sv =====
// Datapath: rate and next-release registers, result registers, multiplier and divider.
`default_nettype none

module vtrs_dp #(
	parameter int TICKS_PER_SECOND = vtrs_pkg::TICKS_PER_SECOND_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_we,
	input  wire  [vtrs_pkg::RATE_W-1:0]  cfg_wdata,
	input  wire  [vtrs_pkg::TIME_W-1:0]  current_time,
	input  wire  [vtrs_pkg::COUNT_W-1:0] byte_count,
	output logic [vtrs_pkg::TIME_W-1:0]  release_time,
	output logic [vtrs_pkg::TIME_W-1:0]  wait_ticks,
	output logic                         must_wait,
	input  vtrs_pkg::vtrs_cmd_t          cmd,
	output vtrs_pkg::vtrs_sts_t          sts
);
	import vtrs_pkg::*;

	localparam int TPS_W  = $clog2(TICKS_PER_SECOND + 1);
	localparam int PROD_W = COUNT_W + TPS_W;
	localparam int CMP_W  = (PROD_W > TIME_W) ? PROD_W : TIME_W;
	localparam logic [TPS_W-1:0]  TPS_C    = TPS_W'(TICKS_PER_SECOND);
	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	logic [RATE_W-1:0]  rate_q;
	logic [TIME_W-1:0]  next_q;
	logic [COUNT_W-1:0] bytes_q;
	logic [TIME_W-1:0]  base_q;
	logic [PROD_W-1:0]  quo_q;    // dividend, shifted out as quotient bits come in
	logic [RATE_W-1:0]  rem_q;

	logic               later;
	logic [TIME_W-1:0]  rel_c;
	logic [RATE_W:0]    rem_sh;
	logic [RATE_W+1:0]  rem_diff;
	logic               borrow;
	logic [TIME_W-1:0]  headroom;
	logic               sat;

	assign sts.limit_on = (rate_q != '0) && (byte_count != '0);

	// release at the stored time only when it lies ahead of now
	assign later = sts.limit_on && (next_q > current_time);
	assign rel_c = later ? next_q : current_time;

	assign rem_sh   = {rem_q, quo_q[PROD_W-1]};
	assign rem_diff = {1'b0, rem_sh} - {2'b00, rate_q};
	assign borrow   = rem_diff[RATE_W+1];

	assign headroom = TIME_MAX - base_q;
	assign sat      = CMP_W'(quo_q) >= CMP_W'(headroom);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= '0;
			next_q <= '0;
		end else begin
			if (cfg_we) begin
				rate_q <= cfg_wdata;
				next_q <= '0;
			end else if (cmd.commit) begin
				next_q <= sat ? TIME_MAX : base_q + quo_q[TIME_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			bytes_q      <= byte_count;
			base_q       <= rel_c;
			release_time <= rel_c;
			must_wait    <= later;
			wait_ticks   <= later ? next_q - current_time : '0;
		end
		if (cmd.mul) begin
			quo_q <= PROD_W'(bytes_q) * PROD_W'(TPS_C);
			rem_q <= '0;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[PROD_W-2:0], !borrow};
			rem_q <= borrow ? rem_sh[RATE_W-1:0] : rem_diff[RATE_W-1:0];
		end
	end

endmodule

`default_nettype wire

// ===== src/virtual_time_rate_shaper_core.sv =====
// Top level of the virtual-time byte-rate shaper.
//
//   channel  dir  handshake             payload
//   cfg      in   cfg_we                cfg_wdata (limit rate, bytes/s)
//   in       in   in_valid / in_stall   current_time, byte_count
//   out      out  out_valid / out_stall release_time, wait_ticks, must_wait
//
// The result is loaded in the cycle the request transaction is accepted.
// Unlimited requests (rate or byte count zero) pass one per cycle while out_stall is low;
// limited ones keep in_stall high through the multiply, the bit-serial division of
// bytes*ticks by the rate and the commit, so a new request waits for the last one.
// Reset clears the rate and next release time; a rate write clears the latter.
// in_stall also rises while a result waits and out_stall is high.
`default_nettype none

module virtual_time_rate_shaper_core #(
	parameter int TICKS_PER_SECOND = vtrs_pkg::TICKS_PER_SECOND_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_we,
	input  wire  [vtrs_pkg::RATE_W-1:0]  cfg_wdata,
	input  wire                          in_valid,
	output logic                         in_stall,
	input  wire  [vtrs_pkg::TIME_W-1:0]  current_time,
	input  wire  [vtrs_pkg::COUNT_W-1:0] byte_count,
	output logic                         out_valid,
	input  wire                          out_stall,
	output logic [vtrs_pkg::TIME_W-1:0]  release_time,
	output logic [vtrs_pkg::TIME_W-1:0]  wait_ticks,
	output logic                         must_wait
);
	import vtrs_pkg::*;

	localparam int PROD_W = COUNT_W + $clog2(TICKS_PER_SECOND + 1);

	vtrs_cmd_t cmd;
	vtrs_sts_t sts;

	vtrs_ctrl #(
		.DIV_STEPS (PROD_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	vtrs_dp #(
		.TICKS_PER_SECOND (TICKS_PER_SECOND)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.current_time (current_time),
		.byte_count   (byte_count),
		.release_time (release_time),
		.wait_ticks   (wait_ticks),
		.must_wait    (must_wait),
		.cmd          (cmd),
		.sts          (sts)
	);

endmodule

`default_nettype wire

// ===== bench/vtrs_checker.sv =====
// Checker for the rate shaper: predicts each release from the request channel and compares results.
module vtrs_checker (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_we,
	input  wire  [vtrs_pkg::RATE_W-1:0]  cfg_wdata,
	input  wire                          in_valid,
	input  wire                          in_stall,
	input  wire  [vtrs_pkg::TIME_W-1:0]  current_time,
	input  wire  [vtrs_pkg::COUNT_W-1:0] byte_count,
	input  wire                          out_valid,
	input  wire                          out_stall,
	input  wire  [vtrs_pkg::TIME_W-1:0]  release_time,
	input  wire  [vtrs_pkg::TIME_W-1:0]  wait_ticks,
	input  wire                          must_wait,
	output int                           mismatches,
	output int                           outstanding,
	output int                           checked,
	output int                           held_late
);
	timeunit 1ns;
	timeprecision 1ps;
	import vtrs_pkg::*;

	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	typedef struct packed {
		logic [TIME_W-1:0] release_at;
		logic [TIME_W-1:0] wait_for;
		logic              must_hold;
	} release_slot_t;

	logic [RATE_W-1:0] shaping_rate;
	logic [TIME_W-1:0] next_slot;
	release_slot_t     release_slots[$];

	// Virtual scheduling: with rate and bytes nonzero, release at the later of the stored slot and
	// now, then push the slot out by this request's transfer time, clamped at the time maximum.
	function automatic release_slot_t schedule_request(input logic [TIME_W-1:0] now,
			input logic [COUNT_W-1:0] bytes);
		release_slot_t     slot;
		logic [63:0]       transfer;
		logic [TIME_W-1:0] start;
		slot.release_at = now;
		if (shaping_rate != '0 && bytes != '0) begin
			start = (next_slot < now) ? now : next_slot;
			transfer = (64'(bytes) * 64'(TICKS_PER_SECOND_DEF)) / 64'(shaping_rate);
			slot.release_at = start;
			if (transfer >= 64'(TIME_MAX - start))
				next_slot = TIME_MAX;
			else
				next_slot = start + transfer[TIME_W-1:0];
		end
		slot.must_hold = slot.release_at > now;
		slot.wait_for = slot.must_hold ? slot.release_at - now : '0;
		return slot;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		release_slot_t want;
		if (!arst_n) begin
			shaping_rate = '0;
			next_slot = '0;
			release_slots.delete();
			mismatches = 0;
			outstanding = 0;
			checked = 0;
			held_late = 0;
		end else begin
			if (cfg_we) begin
				shaping_rate = cfg_wdata;
				next_slot = '0;
			end
			if (in_valid && !in_stall)
				release_slots.push_back(schedule_request(current_time, byte_count));
			if (out_valid && !out_stall) begin
				if (release_slots.size() == 0) begin
					mismatches++;
					$display("%0t unexpected result: expected none, actual release %h wait %h flag %b",
						$time, release_time, wait_ticks, must_wait);
				end else begin
					want = release_slots.pop_front();
					checked++;
					if (want.must_hold)
						held_late++;
					if (release_time !== want.release_at) begin
						mismatches++;
						$display("%0t release_time: expected %h actual %h",
							$time, want.release_at, release_time);
					end
					if (wait_ticks !== want.wait_for) begin
						mismatches++;
						$display("%0t wait_ticks: expected %h actual %h",
							$time, want.wait_for, wait_ticks);
					end
					if (must_wait !== want.must_hold) begin
						mismatches++;
						$display("%0t must_wait: expected %b actual %b",
							$time, want.must_hold, must_wait);
					end
				end
			end
			outstanding = release_slots.size();
		end
	end

endmodule

// ===== bench/tb_virtual_time_rate_shaper_core.sv =====
// Testbench top for the rate shaper: clock, reset, rate writes, request traffic and verdict.
module tb_virtual_time_rate_shaper_core;
	timeunit 1ns;
	timeprecision 1ps;
	import vtrs_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYCLES = 80;
	localparam int PHASE_COUNT = 8;
	localparam int ITEMS_PER_PHASE = 104;
	localparam int HOLD_OFF_CYCLES = 600;
	localparam logic [TIME_W-1:0]  TIME_MAX  = '1;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [RATE_W-1:0]  RATE_MAX  = '1;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [RATE_W-1:0]   cfg_wdata = '0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [TIME_W-1:0]   current_time = '0;
	logic [COUNT_W-1:0]  byte_count = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [TIME_W-1:0]   release_time;
	logic [TIME_W-1:0]   wait_ticks;
	logic                must_wait;

	int          mismatch_total;
	int          awaiting;
	int          checked_total;
	int          late_total;
	int          send_gap_pct = 0;
	int          stall_pct = 0;
	logic        pressure_on = 1'b0;
	int          rate_writes = 0;
	logic [RATE_W-1:0] rate_now = '0;
	int unsigned cycle_count = 0;

	always #6 clk = ~clk;

	virtual_time_rate_shaper_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.current_time (current_time),
		.byte_count   (byte_count),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.release_time (release_time),
		.wait_ticks   (wait_ticks),
		.must_wait    (must_wait)
	);

	vtrs_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.current_time (current_time),
		.byte_count   (byte_count),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.release_time (release_time),
		.wait_ticks   (wait_ticks),
		.must_wait    (must_wait),
		.mismatches   (mismatch_total),
		.outstanding  (awaiting),
		.checked      (checked_total),
		.held_late    (late_total)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count, awaiting);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Result side: random stall, plus one long hold-off once pressure is requested.
	initial begin
		int   hold_left;
		logic held_once;
		hold_left = 0;
		held_once = 1'b0;
		forever begin
			@(posedge clk);
			if (pressure_on && !held_once) begin
				held_once = 1'b1;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// Offers one request; valid stays high after the transaction unless the next one idles first.
	task automatic send_request(input logic [TIME_W-1:0] stamp, input logic [COUNT_W-1:0] bytes);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		current_time <= stamp;
		byte_count <= bytes;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	// Rate writes only once the block has drained and finished its division.
	task automatic write_rate(input logic [RATE_W-1:0] value);
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (awaiting != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		rate_now = value;
		rate_writes++;
	endtask

	initial begin
		logic [TIME_W-1:0]  clock_now;
		logic [TIME_W-1:0]  stamp;
		logic [COUNT_W-1:0] bytes;
		logic [RATE_W-1:0]  phase_rate;
		logic [63:0]        typical;
		logic [63:0]        step;
		int                 pick;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// limiting off: everything goes at once
		write_rate('0);
		send_request('0, '0);
		send_request(TIME_MAX, COUNT_MAX);
		send_request(48'd12345, 32'd1);

		// slowest rate: huge delays, saturation, then time running backwards
		write_rate(40'd1);
		send_request(48'd100, 32'd1);
		send_request(48'd200, 32'd0);
		send_request(48'd300, 32'd7);
		send_request(TIME_MAX - 48'd5, COUNT_MAX);
		send_request(48'd50, 32'd1);
		send_request(TIME_MAX, 32'd1);

		// fastest rate: delays round down to nothing for small requests
		write_rate(RATE_MAX);
		send_request(48'd1000, 32'd1);
		send_request(48'd999, 32'd5);
		send_request(48'd2000, COUNT_MAX);
		send_request(48'd2001, 32'd1000);

		write_rate(40'd1000000);
		send_request('0, 32'd1500);
		send_request('0, 32'd1500);
		send_request(48'd3000000, 32'd64);
		send_request(48'd10000000, 32'd64);
		send_request(48'h5555_5555_5555, 32'hAAAA_AAAA);

		for (int phase = 0; phase < PHASE_COUNT; phase++) begin
			case (phase)
				0: phase_rate = 40'd125000000;
				1: phase_rate = 40'd1000000;
				2: phase_rate = {8'($urandom), 32'($urandom)};
				3: phase_rate = RATE_MAX;
				4: phase_rate = 40'd1;
				5: phase_rate = '0;
				6: phase_rate = 40'($urandom_range(100000, 1000));
				default: phase_rate = 40'd12500000000;
			endcase
			write_rate(phase_rate);
			case (phase % 4)
				0: begin send_gap_pct = 0;  stall_pct <= 0;  end
				1: begin send_gap_pct = 60; stall_pct <= 0;  end
				2: begin send_gap_pct = 0;  stall_pct <= 60; end
				default: begin send_gap_pct = 33; stall_pct <= 33; end
			endcase
			pressure_on <= (phase == 2);
			clock_now = {16'($urandom_range(3)), 32'($urandom)};

			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				pick = $urandom_range(99);
				if (pick < 70) begin
					// paced traffic: arrivals land both ahead of and behind the stored slot
					bytes = ($urandom_range(3) == 0) ? 32'($urandom_range(9000, 1))
						: 32'($urandom_range(1500, 64));
					typical = (rate_now == '0) ? 64'd1000
						: (64'(bytes) * 64'(TICKS_PER_SECOND_DEF)) / 64'(rate_now);
					if (typical > 64'h100_0000_0000)
						typical = 64'h100_0000_0000;
					step = (typical * 64'($urandom_range(200))) / 64'd100;
					clock_now = clock_now + step[TIME_W-1:0];
					stamp = clock_now;
				end else if (pick < 80) begin
					bytes = '0;
					clock_now = clock_now + 48'($urandom_range(5000));
					stamp = clock_now;
				end else if (pick < 90) begin
					bytes = 32'($urandom_range(1500, 1));
					stamp = clock_now - 48'($urandom_range(100000));
				end else begin
					bytes = $urandom;
					stamp = {16'($urandom), 32'($urandom)};
				end
				send_request(stamp, bytes);
			end
		end

		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (awaiting != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Shaped %0d requests under %0d rate settings; %0d were held past arrival.",
			checked_total, rate_writes, late_total);
		$display("Traffic ran gap-free, with sender gaps, receiver stalls, both, and a long hold-off.");
		if (mismatch_total == 0 && awaiting == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== virtual_time_rate_shaper_core.f =====
src/vtrs_pkg.sv
src/vtrs_ctrl.sv
src/vtrs_dp.sv
src/virtual_time_rate_shaper_core.sv
bench/vtrs_checker.sv
bench/tb_virtual_time_rate_shaper_core.sv
